// ===== rtl/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants for the depth region occupancy centroid block.
// ----------------------------------------------------------------------------
package drc_pkg;

    localparam int COORD_W = 11;
    localparam int DEPTH_W = 16;

    localparam int DEF_COORD_BITS        = 11;
    localparam int DEF_MAX_REGION_PIXELS = 4096;

    localparam logic [DEPTH_W-1:0] NEAR_THRESHOLD_RESET = 16'd3801;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [DEPTH_W-1:0] pixel_depth;
        logic               last_of_region;
    } pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [DEPTH_W-1:0] mean_depth;
        logic               occupied;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_LOAD
    } state_t;

    typedef enum logic [1:0] {
        FLD_X,
        FLD_Y,
        FLD_DEPTH
    } div_field_t;

endpackage

// ===== rtl/drc_accum.sv =====
// ----------------------------------------------------------------------------
// drc_accum
// Per-class sums and pixel counts; presents the class chosen for the result.
// ----------------------------------------------------------------------------
module drc_accum #(
    parameter int COORD_BITS        = drc_pkg::DEF_COORD_BITS,
    parameter int MAX_REGION_PIXELS = drc_pkg::DEF_MAX_REGION_PIXELS,
    parameter int CNT_W             = $clog2(MAX_REGION_PIXELS + 1),
    parameter int SUM_C_W           = COORD_BITS + $clog2(MAX_REGION_PIXELS),
    parameter int SUM_D_W           = drc_pkg::DEPTH_W + $clog2(MAX_REGION_PIXELS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       add,
    input  logic                       clear,
    input  logic [drc_pkg::DEPTH_W-1:0] threshold,
    input  logic [COORD_BITS-1:0]      x,
    input  logic [COORD_BITS-1:0]      y,
    input  logic [drc_pkg::DEPTH_W-1:0] depth,
    output logic [SUM_C_W-1:0]         sel_sum_x,
    output logic [SUM_C_W-1:0]         sel_sum_y,
    output logic [SUM_D_W-1:0]         sel_sum_depth,
    output logic [CNT_W-1:0]           sel_count,
    output logic                       sel_object
);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_REGION_PIXELS);

    logic [SUM_C_W-1:0] obj_sx_reg, obj_sy_reg, bg_sx_reg, bg_sy_reg;
    logic [SUM_D_W-1:0] obj_sd_reg, bg_sd_reg;
    logic [CNT_W-1:0]   obj_cnt_reg, bg_cnt_reg;

    logic is_object;
    logic obj_add;
    logic bg_add;

    assign is_object = depth < threshold;
    // a full class drops further pixels until the region ends
    assign obj_add   = add && is_object && (obj_cnt_reg < CNT_FULL);
    assign bg_add    = add && !is_object && (bg_cnt_reg < CNT_FULL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_sx_reg  <= '0;
            obj_sy_reg  <= '0;
            obj_sd_reg  <= '0;
            obj_cnt_reg <= '0;
            bg_sx_reg   <= '0;
            bg_sy_reg   <= '0;
            bg_sd_reg   <= '0;
            bg_cnt_reg  <= '0;
        end
        else if (clear)
        begin
            obj_sx_reg  <= '0;
            obj_sy_reg  <= '0;
            obj_sd_reg  <= '0;
            obj_cnt_reg <= '0;
            bg_sx_reg   <= '0;
            bg_sy_reg   <= '0;
            bg_sd_reg   <= '0;
            bg_cnt_reg  <= '0;
        end
        else
        begin
            if (obj_add)
            begin
                obj_sx_reg  <= obj_sx_reg + SUM_C_W'(x);
                obj_sy_reg  <= obj_sy_reg + SUM_C_W'(y);
                obj_sd_reg  <= obj_sd_reg + SUM_D_W'(depth);
                obj_cnt_reg <= obj_cnt_reg + CNT_W'(1);
            end
            if (bg_add)
            begin
                bg_sx_reg  <= bg_sx_reg + SUM_C_W'(x);
                bg_sy_reg  <= bg_sy_reg + SUM_C_W'(y);
                bg_sd_reg  <= bg_sd_reg + SUM_D_W'(depth);
                bg_cnt_reg <= bg_cnt_reg + CNT_W'(1);
            end
        end
    end

    assign sel_object    = (obj_cnt_reg != '0);
    assign sel_sum_x     = sel_object ? obj_sx_reg  : bg_sx_reg;
    assign sel_sum_y     = sel_object ? obj_sy_reg  : bg_sy_reg;
    assign sel_sum_depth = sel_object ? obj_sd_reg  : bg_sd_reg;
    assign sel_count     = sel_object ? obj_cnt_reg : bg_cnt_reg;

endmodule

// ===== rtl/drc_divider.sv =====
// ----------------------------------------------------------------------------
// drc_divider
// Restoring divider, one quotient bit per cycle, shared by all three means.
// ----------------------------------------------------------------------------
module drc_divider #(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVIDEND_W-1:0] dq_reg, dq_next;

    logic [DIVISOR_W:0] shifted;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    // dq_reg shifts the dividend out at the top and the quotient in at the bottom
    assign shifted = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dq_next   = dq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W - 1);
            rem_next  = '0;
            dsr_next  = divisor;
            dq_next   = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            dq_next   = {dq_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dq_reg  <= dq_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ===== rtl/depth_region_occupancy_centroid.sv =====
// ----------------------------------------------------------------------------
// depth_region_occupancy_centroid
// Thresholded region centroid over a stream of depth pixels.
// ----------------------------------------------------------------------------
// Pixels that do not end a region: one per cycle, no result.
// Region's last pixel: three serial divisions (x, y, then mean depth) of
//   width W = 16 + clog2(MAX_REGION_PIXELS) for COORD_BITS <= 16, then the
//   result is loaded into the output register; pixel input stalls meanwhile.
// Reset: near_threshold = 3801, all sums and counts zero, no result pending.
// ----------------------------------------------------------------------------
module depth_region_occupancy_centroid #(
    parameter int COORD_BITS        = drc_pkg::DEF_COORD_BITS,
    parameter int MAX_REGION_PIXELS = drc_pkg::DEF_MAX_REGION_PIXELS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [drc_pkg::DEPTH_W-1:0] cfg_data,
    input  logic                        pixel_valid,
    output logic                        pixel_stall,
    input  drc_pkg::pixel_t             pixel,
    output logic                        result_valid,
    input  logic                        result_stall,
    output drc_pkg::result_t            result
);

    localparam int CNT_W   = $clog2(MAX_REGION_PIXELS + 1);
    localparam int LOG_W   = $clog2(MAX_REGION_PIXELS);
    localparam int SUM_C_W = COORD_BITS + LOG_W;
    localparam int SUM_D_W = drc_pkg::DEPTH_W + LOG_W;
    localparam int DIV_W   = (SUM_C_W > SUM_D_W) ? SUM_C_W : SUM_D_W;

    drc_pkg::state_t     state_reg, state_next;
    drc_pkg::div_field_t field_reg, field_next;

    logic [drc_pkg::DEPTH_W-1:0] thresh_reg;
    logic                        result_valid_reg, result_valid_next;
    drc_pkg::result_t            result_reg, result_next;
    logic [drc_pkg::COORD_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [drc_pkg::DEPTH_W-1:0] qd_reg, qd_next;
    logic                        occ_reg, occ_next;

    logic                  pixel_xfer;
    logic                  acc_clear;
    logic                  div_start;
    logic                  div_done;
    logic [DIV_W-1:0]      div_dividend;
    logic [DIV_W-1:0]      div_quotient;
    logic [DIV_W-1:0]      quot_masked;
    logic [SUM_C_W-1:0]    sel_sum_x, sel_sum_y;
    logic [SUM_D_W-1:0]    sel_sum_depth;
    logic [CNT_W-1:0]      sel_count;
    logic                  sel_object;

    assign pixel_stall = (state_reg != drc_pkg::ST_IDLE);
    assign pixel_xfer  = pixel_valid && !pixel_stall;

    drc_accum #(
        .COORD_BITS        (COORD_BITS),
        .MAX_REGION_PIXELS (MAX_REGION_PIXELS),
        .CNT_W             (CNT_W),
        .SUM_C_W           (SUM_C_W),
        .SUM_D_W           (SUM_D_W)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .add           (pixel_xfer),
        .clear         (acc_clear),
        .threshold     (thresh_reg),
        .x             (COORD_BITS'(pixel.pixel_x)),
        .y             (COORD_BITS'(pixel.pixel_y)),
        .depth         (pixel.pixel_depth),
        .sel_sum_x     (sel_sum_x),
        .sel_sum_y     (sel_sum_y),
        .sel_sum_depth (sel_sum_depth),
        .sel_count     (sel_count),
        .sel_object    (sel_object)
    );

    always_comb
    begin
        case (field_reg)
            drc_pkg::FLD_X:     div_dividend = DIV_W'(sel_sum_x);
            drc_pkg::FLD_Y:     div_dividend = DIV_W'(sel_sum_y);
            default:            div_dividend = DIV_W'(sel_sum_depth);
        endcase
    end

    drc_divider #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (sel_count),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // an empty chosen class yields zeros rather than the all-ones of a /0
    assign quot_masked = (sel_count == '0) ? '0 : div_quotient;

    always_comb
    begin
        state_next        = state_reg;
        field_next        = field_reg;
        qx_next           = qx_reg;
        qy_next           = qy_reg;
        qd_next           = qd_reg;
        occ_next          = occ_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        div_start         = 1'b0;
        acc_clear         = 1'b0;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            drc_pkg::ST_IDLE:
            begin
                if (pixel_xfer && pixel.last_of_region)
                begin
                    field_next = drc_pkg::FLD_X;
                    state_next = drc_pkg::ST_START;
                end
            end
            drc_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = drc_pkg::ST_WAIT;
            end
            drc_pkg::ST_WAIT:
            begin
                if (div_done)
                begin
                    unique case (field_reg)
                        drc_pkg::FLD_X:
                        begin
                            qx_next    = drc_pkg::COORD_W'(quot_masked);
                            field_next = drc_pkg::FLD_Y;
                            state_next = drc_pkg::ST_START;
                        end
                        drc_pkg::FLD_Y:
                        begin
                            qy_next    = drc_pkg::COORD_W'(quot_masked);
                            field_next = drc_pkg::FLD_DEPTH;
                            state_next = drc_pkg::ST_START;
                        end
                        default:
                        begin
                            qd_next    = drc_pkg::DEPTH_W'(quot_masked);
                            occ_next   = sel_object;
                            acc_clear  = 1'b1;
                            state_next = drc_pkg::ST_LOAD;
                        end
                    endcase
                end
            end
            drc_pkg::ST_LOAD:
            begin
                // wait for the output register to be free
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.center_x   = qx_reg;
                    result_next.center_y   = qy_reg;
                    result_next.mean_depth = qd_reg;
                    result_next.occupied   = occ_reg;
                    result_valid_next      = 1'b1;
                    state_next             = drc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = drc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= drc_pkg::ST_IDLE;
            field_reg        <= drc_pkg::FLD_X;
            result_valid_reg <= 1'b0;
            thresh_reg       <= drc_pkg::NEAR_THRESHOLD_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            field_reg        <= field_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                thresh_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        qd_reg     <= qd_next;
        occ_reg    <= occ_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
